FILE: rtl/vsa_pkg.sv
// ----------------------------------------------------------------------------
// vsa_pkg
// Shared types, codes and constants of the voice stealing allocator.
// ----------------------------------------------------------------------------
package vsa_pkg;

	localparam int unsigned VOICE_COUNT_DEF = 24;
	localparam int unsigned AGE_BITS_DEF    = 32;

	localparam int unsigned SOUND_W = 8;
	localparam int unsigned VOICE_W = 5;

	localparam logic [15:0]        SCORE_FREE       = 16'hFFFF;
	localparam logic [15:0]        SCORE_USED_BONUS = 16'h7777;
	localparam logic [SOUND_W-1:0] SOUND_NONE       = 8'hFF;

	typedef enum logic [1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE  = 2'd1,
		OP_CLEAR = 2'd2
	} opcode_t;

	typedef enum logic [1:0] {
		ST_ALLOC   = 2'd0,
		ST_FREED   = 2'd1,
		ST_INVALID = 2'd2,
		ST_CLEARED = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		MODE_FREE   = 2'd0,
		MODE_USED   = 2'd1,
		MODE_LOCKED = 2'd2,
		MODE_STEAL  = 2'd3
	} mode_t;

	localparam logic [1:0] KIND_ONE_SHOT = 2'd0;
	localparam logic [1:0] KIND_LOCKED   = 2'd1;

	// Commands broadcast from the sequencer to every cell.
	typedef struct packed {
		logic                age_en;
		logic                clr_all;
		logic                free_en;
		logic                alloc_en;
		mode_t               mode;
		logic [SOUND_W-1:0]  sound;
	} vsa_ctrl_t;

	function automatic mode_t mode_of_kind(input logic [1:0] kind);
		mode_t m;
		case (kind)
			KIND_ONE_SHOT: m = MODE_USED;
			KIND_LOCKED:   m = MODE_LOCKED;
			default:       m = MODE_STEAL;
		endcase
		return m;
	endfunction

endpackage

FILE: rtl/vsa_req_if.sv
// ----------------------------------------------------------------------------
// vsa_req_if
// Request channel of the voice allocator: valid, ready and request fields.
// ----------------------------------------------------------------------------
interface vsa_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic [1:0] loop_kind;
	logic [7:0] sound_id;
	logic [4:0] voice_in;

	modport source (output valid, opcode, loop_kind, sound_id, voice_in, input ready);
	modport sink   (input valid, opcode, loop_kind, sound_id, voice_in, output ready);
endinterface

FILE: rtl/vsa_rsp_if.sv
// ----------------------------------------------------------------------------
// vsa_rsp_if
// Response channel of the voice allocator: valid, ready and result fields.
// ----------------------------------------------------------------------------
interface vsa_rsp_if;
	logic       valid;
	logic       ready;
	logic [4:0] voice_out;
	logic [1:0] status;

	modport source (output valid, voice_out, status, input ready);
	modport sink   (input valid, voice_out, status, output ready);
endinterface

FILE: rtl/vsa_cell.sv
// ----------------------------------------------------------------------------
// vsa_cell
// One voice entry with its aging counter and one stage of the best-score chain.
// ----------------------------------------------------------------------------
module vsa_cell
	import vsa_pkg::*;
#(
	parameter int unsigned AGE_BITS = AGE_BITS_DEF,
	parameter int unsigned IDX_W    = 5,
	localparam int unsigned SCORE_W = AGE_BITS + 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  vsa_ctrl_t          ctrl,
	input  logic [IDX_W-1:0]   idx,
	input  logic [IDX_W-1:0]   sel_idx,
	input  logic [SCORE_W-1:0] best_score_in,
	input  logic [IDX_W-1:0]   best_idx_in,
	output logic [SCORE_W-1:0] best_score_out,
	output logic [IDX_W-1:0]   best_idx_out,
	output logic               busy
);

	mode_t               mode_q;
	logic [AGE_BITS-1:0] age_q;
	logic [SOUND_W-1:0]  sound_q;
	logic [SCORE_W-1:0]  score;
	logic [SCORE_W-1:0]  best_score_q;
	logic [IDX_W-1:0]    best_idx_q;
	logic                hit;

	assign hit = (sel_idx == idx);

	// A locked loop scores zero here, which never beats the running best.
	always_comb begin
		case (mode_q)
			MODE_FREE:   score = SCORE_W'(SCORE_FREE);
			MODE_USED:   score = {1'b0, age_q} + SCORE_W'(SCORE_USED_BONUS);
			MODE_LOCKED: score = '0;
			default:     score = {1'b0, age_q};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_FREE;
			age_q   <= '0;
			sound_q <= SOUND_NONE;
		end else if (ctrl.clr_all || (ctrl.free_en && hit)) begin
			mode_q  <= MODE_FREE;
			age_q   <= '0;
			sound_q <= SOUND_NONE;
		end else if (ctrl.alloc_en && hit) begin
			mode_q  <= ctrl.mode;
			age_q   <= AGE_BITS'(1);
			sound_q <= ctrl.sound;
		end else if (ctrl.age_en && (age_q != '1)) begin
			age_q <= age_q + AGE_BITS'(1);
		end
	end

	// The running best moves one cell further every cycle.
	always_ff @(posedge clk) begin
		if (score > best_score_in) begin
			best_score_q <= score;
			best_idx_q   <= idx;
		end else begin
			best_score_q <= best_score_in;
			best_idx_q   <= best_idx_in;
		end
	end

	assign best_score_out = best_score_q;
	assign best_idx_out   = best_idx_q;
	assign busy           = (mode_q != MODE_FREE) || (sound_q != SOUND_NONE && 1'b0);

endmodule

FILE: rtl/voice_stealing_allocator.sv
// ----------------------------------------------------------------------------
// voice_stealing_allocator
// Voice allocator with age-scored stealing over a chain of voice cells.
// ----------------------------------------------------------------------------
// Free, clear and invalid requests: result register loaded at accept; the next
// request can be taken in the following cycle once the response is taken.
// Allocate: from accept to result the request passes an aging state, the best
// score crossing the cell chain one cell per cycle, then a write-back state that
// also loads the result register; the next request is taken with the result.
// Reset clears every voice entry to free, age zero, no sound.
module voice_stealing_allocator
	import vsa_pkg::*;
#(
	parameter int unsigned VOICE_COUNT = VOICE_COUNT_DEF,
	parameter int unsigned AGE_BITS    = AGE_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	vsa_req_if.sink   req,
	vsa_rsp_if.source rsp
);

	localparam int unsigned IDX_W   = $clog2(VOICE_COUNT);
	localparam int unsigned SCORE_W = AGE_BITS + 1;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_AGE  = 4'b0010,
		S_WAVE = 4'b0100,
		S_FIN  = 4'b1000
	} state_t;

	state_t             state_q;
	logic [IDX_W-1:0]   cnt_q;
	logic [1:0]         kind_q;
	logic [SOUND_W-1:0] sound_q;
	logic               out_valid_q;
	logic [VOICE_W-1:0] voice_out_q;
	status_t            status_q;

	logic               out_free;
	logic               accept;
	logic               voice_ok;
	logic               out_wr;
	logic [VOICE_W-1:0] out_voice;
	status_t            out_status;
	vsa_ctrl_t          ctrl;
	logic [IDX_W-1:0]   sel_idx;

	logic [SCORE_W-1:0]   best_score [VOICE_COUNT];
	logic [IDX_W-1:0]     best_idx   [VOICE_COUNT];
	logic [VOICE_COUNT-1:0] busy;

	assign out_free  = !out_valid_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE) && out_free;
	assign accept    = req.valid && req.ready;
	assign voice_ok  = 32'(req.voice_in) < 32'(VOICE_COUNT);

	always_comb begin
		ctrl       = '0;
		ctrl.mode  = mode_of_kind(kind_q);
		ctrl.sound = sound_q;
		sel_idx    = IDX_W'(req.voice_in);
		out_wr     = 1'b0;
		out_voice  = req.voice_in;
		out_status = ST_INVALID;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (req.opcode)
						OP_ALLOC: ;
						OP_FREE: begin
							ctrl.free_en = voice_ok;
							out_wr       = 1'b1;
							out_status   = voice_ok ? ST_FREED : ST_INVALID;
						end
						OP_CLEAR: begin
							ctrl.clr_all = 1'b1;
							out_wr       = 1'b1;
							out_voice    = '0;
							out_status   = ST_CLEARED;
						end
						default: begin
							out_wr = 1'b1;
						end
					endcase
				end
			end
			S_AGE: begin
				ctrl.age_en = 1'b1;
			end
			S_WAVE: ;
			S_FIN: begin
				sel_idx = best_idx[VOICE_COUNT-1];
				if (out_free) begin
					ctrl.alloc_en = 1'b1;
					out_wr        = 1'b1;
					out_voice     = VOICE_W'(best_idx[VOICE_COUNT-1]);
					out_status    = ST_ALLOC;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept && req.opcode == OP_ALLOC) begin
						state_q <= S_AGE;
					end
				end
				S_AGE: begin
					cnt_q   <= '0;
					state_q <= S_WAVE;
				end
				S_WAVE: begin
					if (cnt_q == IDX_W'(VOICE_COUNT - 1)) begin
						state_q <= S_FIN;
					end else begin
						cnt_q <= cnt_q + IDX_W'(1);
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q  <= req.loop_kind;
			sound_q <= req.sound_id;
		end
		if (out_wr) begin
			voice_out_q <= out_voice;
			status_q    <= out_status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_wr) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.voice_out = voice_out_q;
	assign rsp.status    = status_q;

	for (genvar i = 0; i < VOICE_COUNT; i++) begin : g_cell
		logic [SCORE_W-1:0] score_in;
		logic [IDX_W-1:0]   idx_in;

		if (i == 0) begin : g_head
			assign score_in = '0;
			assign idx_in   = '0;
		end else begin : g_link
			assign score_in = best_score[i-1];
			assign idx_in   = best_idx[i-1];
		end

		vsa_cell #(
			.AGE_BITS (AGE_BITS),
			.IDX_W    (IDX_W)
		) u_cell (
			.clk            (clk),
			.arst_n         (arst_n),
			.ctrl           (ctrl),
			.idx            (IDX_W'(i)),
			.sel_idx        (sel_idx),
			.best_score_in  (score_in),
			.best_idx_in    (idx_in),
			.best_score_out (best_score[i]),
			.best_idx_out   (best_idx[i]),
			.busy           (busy[i])
		);
	end

	// The winner handed back at write-back always names an existing voice.
	a_win_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN) |-> (32'(best_idx[VOICE_COUNT-1]) < 32'(VOICE_COUNT)))
		else $error("allocated voice index out of range");

	// A clear leaves every voice free in the next cycle.
	a_clear_all: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.opcode == OP_CLEAR) |=> (busy == '0))
		else $error("voices still busy after clear");

	// An allocate always leaves at least one voice busy after write-back.
	a_alloc_marks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && out_free) |=> (busy != '0))
		else $error("allocate left all voices free");

	// The chain walk never runs past the last cell.
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WAVE) |-> (32'(cnt_q) < 32'(VOICE_COUNT)))
		else $error("chain walk counter out of range");

endmodule
